// ===== src/spr_pkg.sv =====
package spr_pkg;

    localparam int DIAL_W   = 11;
    localparam int PULSE_W  = 12;
    localparam int STEP_W   = 8;
    localparam int THR_W    = 10;
    localparam int HOLD_W   = 11;
    localparam int PHASE_W  = 3;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CALC_W   = 14;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_PULSE      = 3'd0,
        REG_MAX_PULSE      = 3'd1,
        REG_STEP_SIZE      = 3'd2,
        REG_OPEN_LEVEL     = 3'd3,
        REG_CLOSE_LEVEL    = 3'd4,
        REG_DIAL_THRESHOLD = 3'd5,
        REG_HOLD_TICKS     = 3'd6
    } cfg_reg_t;

    localparam logic [PHASE_W-1:0] PHASE_NUDGE_DOWN = 3'd1;
    localparam logic [PHASE_W-1:0] PHASE_NUDGE_UP_A = 3'd2;
    localparam logic [PHASE_W-1:0] PHASE_NUDGE_UP_B = 3'd3;

    localparam logic [PULSE_W-1:0] MIN_PULSE_RST   = 12'd850;
    localparam logic [PULSE_W-1:0] MAX_PULSE_RST   = 12'd1750;
    localparam logic [STEP_W-1:0]  STEP_SIZE_RST   = 8'd10;
    localparam logic [PULSE_W-1:0] OPEN_LEVEL_RST  = 12'd1350;
    localparam logic [PULSE_W-1:0] CLOSE_LEVEL_RST = 12'd1750;
    localparam logic [THR_W-1:0]   DIAL_THR_RST    = 10'd500;
    localparam logic [THR_W-1:0]   HOLD_TICKS_RST  = 10'd50;
    localparam logic [PULSE_W-1:0] PULSE_RST       = 12'd1750;
    localparam logic [HOLD_W-1:0]  HOLD_MAX        = 11'd2047;

    typedef struct packed {
        logic [PHASE_W-1:0] match_phase;
        logic               switch_up;
        logic               plain_key_held;
        logic               ctrl_key_held;
    } tick_flags_t;

endpackage

// ===== src/servo_pulse_ramp_with_cover_status.sv =====
// channel   dir   handshake          tdata                tuser
// s_*       in    s_tvalid/s_tready  [10:0] dial          [0] ctrl_key_held, [1] plain_key_held,
//                                                         [2] switch_up, [5:3] match_phase
// m_*       out   m_tvalid/m_tready  [11:0] pulse_width   [0] cover_open, [1] status_changed
// cfg_*     in    cfg_we             cfg_index, cfg_wdata (no read-back)
//
// one beat per cycle sustained while the output is not stalled; a beat is captured in the
// input register, is worked out combinationally and lands in the output register.
// the pulse, hold counters and cover status update as a beat moves to the output register.
// reset (rst_n low, asynchronous) restores limits, state and empty stages.
// a stalled output holds both stages and drops s_tready only when both are full.
module servo_pulse_ramp_with_cover_status
    import spr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [10:0] dial
    input  logic [5:0]           s_tuser,   // [0] ctrl, [1] plain, [2] switch_up, [5:3] phase
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // [11:0] pulse_width
    output logic [1:0]           m_tuser,   // [0] cover_open, [1] status_changed
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    logic [PULSE_W-1:0] min_pulse_reg, max_pulse_reg, open_level_reg, close_level_reg;
    logic [STEP_W-1:0]  step_size_reg;
    logic [THR_W-1:0]   dial_thr_reg, hold_ticks_reg;

    logic                      in_valid_reg;
    logic signed [DIAL_W-1:0]  dial_reg;
    tick_flags_t               flags_reg;

    logic [PULSE_W-1:0] pulse_reg, pulse_next;
    logic [HOLD_W-1:0]  ccw_reg, ccw_next, cw_reg, cw_next;
    logic               last_open_reg, last_open_next;

    logic               out_valid_reg;
    logic [PULSE_W-1:0] out_pulse_reg;
    logic               out_open_reg, out_changed_reg;
    logic               changed_next;

    logic out_free, advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pulse_reg   <= MIN_PULSE_RST;
            max_pulse_reg   <= MAX_PULSE_RST;
            step_size_reg   <= STEP_SIZE_RST;
            open_level_reg  <= OPEN_LEVEL_RST;
            close_level_reg <= CLOSE_LEVEL_RST;
            dial_thr_reg    <= DIAL_THR_RST;
            hold_ticks_reg  <= HOLD_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_PULSE:      min_pulse_reg   <= cfg_wdata;
                REG_MAX_PULSE:      max_pulse_reg   <= cfg_wdata;
                REG_STEP_SIZE:      step_size_reg   <= cfg_wdata[STEP_W-1:0];
                REG_OPEN_LEVEL:     open_level_reg  <= cfg_wdata;
                REG_CLOSE_LEVEL:    close_level_reg <= cfg_wdata;
                REG_DIAL_THRESHOLD: dial_thr_reg    <= cfg_wdata[THR_W-1:0];
                REG_HOLD_TICKS:     hold_ticks_reg  <= cfg_wdata[THR_W-1:0];
                default:            ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            dial_reg  <= s_tdata[DIAL_W-1:0];
            flags_reg <= s_tuser;
        end
    end

    // tick update
    logic signed [PULSE_W-1:0] dial_ext, thr_pos, thr_neg;
    logic                      ccw_beyond, cw_beyond;
    logic                      step_down, step_up;
    logic signed [CALC_W-1:0]  p_sum, p_min, p_max;

    always_comb
    begin
        dial_ext   = {dial_reg[DIAL_W-1], dial_reg};
        thr_pos    = signed'({{(PULSE_W-THR_W){1'b0}}, dial_thr_reg});
        thr_neg    = -thr_pos;
        ccw_beyond = dial_ext > thr_pos;
        cw_beyond  = dial_ext < thr_neg;

        ccw_next = !ccw_beyond ? '0 : (ccw_reg == HOLD_MAX) ? HOLD_MAX : ccw_reg + 1'b1;
        cw_next  = !cw_beyond  ? '0 : (cw_reg  == HOLD_MAX) ? HOLD_MAX : cw_reg  + 1'b1;
        if (flags_reg.switch_up)
        begin
            ccw_next = '0;
            cw_next  = '0;
        end

        p_sum = signed'({{(CALC_W-PULSE_W){1'b0}}, pulse_reg});
        if (flags_reg.match_phase == PHASE_NUDGE_DOWN)
            p_sum = p_sum - 14'sd1;
        else if (flags_reg.match_phase == PHASE_NUDGE_UP_A
                 || flags_reg.match_phase == PHASE_NUDGE_UP_B)
            p_sum = p_sum + 14'sd1;

        step_down = flags_reg.ctrl_key_held || (cw_next > {1'b0, hold_ticks_reg});
        step_up   = flags_reg.plain_key_held || (ccw_next > {1'b0, hold_ticks_reg});
        if (step_down)
            p_sum = p_sum - signed'({{(CALC_W-STEP_W){1'b0}}, step_size_reg});
        else if (step_up)
            p_sum = p_sum + signed'({{(CALC_W-STEP_W){1'b0}}, step_size_reg});

        p_min = signed'({{(CALC_W-PULSE_W){1'b0}}, min_pulse_reg});
        p_max = signed'({{(CALC_W-PULSE_W){1'b0}}, max_pulse_reg});
        if (p_sum < p_min)
            pulse_next = min_pulse_reg;
        else if (p_sum > p_max)
            pulse_next = max_pulse_reg;
        else
            pulse_next = p_sum[PULSE_W-1:0];

        // open wins where the levels overlap, between them the status holds
        last_open_next = last_open_reg;
        changed_next   = 1'b0;
        if (pulse_next <= open_level_reg)
        begin
            last_open_next = 1'b1;
            changed_next   = !last_open_reg;
        end
        else if (pulse_next >= close_level_reg)
        begin
            last_open_next = 1'b0;
            changed_next   = last_open_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_reg     <= PULSE_RST;
            ccw_reg       <= '0;
            cw_reg        <= '0;
            last_open_reg <= 1'b0;
        end
        else if (advance)
        begin
            pulse_reg     <= pulse_next;
            ccw_reg       <= ccw_next;
            cw_reg        <= cw_next;
            last_open_reg <= last_open_next;
        end
    end

    // output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_pulse_reg   <= pulse_next;
            out_open_reg    <= last_open_next;
            out_changed_reg <= changed_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(16-PULSE_W){1'b0}}, out_pulse_reg};
    assign m_tuser  = {out_changed_reg, out_open_reg};

endmodule

// ===== tb/tb_servo_pulse_ramp_with_cover_status.sv =====
module tb_servo_pulse_ramp_with_cover_status;
    import spr_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD_OFF = 300;
    localparam logic [PHASE_W-1:0] PHASE_IDLE = '0;

    typedef struct {
        logic [PULSE_W-1:0] pulse_width;
        logic               cover_open;
        logic               status_changed;
    } pulse_beat_t;

    class servo_channel;
        int min_pulse, max_pulse, step_size, open_level, close_level;
        int dial_thr, hold_ticks;
        int pulse, ccw_count, cw_count;
        bit last_open;
        pulse_beat_t pending_beats[$];
        int errors;

        function new();
            min_pulse = MIN_PULSE_RST;
            max_pulse = MAX_PULSE_RST;
            step_size = STEP_SIZE_RST;
            open_level = OPEN_LEVEL_RST;
            close_level = CLOSE_LEVEL_RST;
            dial_thr = DIAL_THR_RST;
            hold_ticks = HOLD_TICKS_RST;
            pulse = PULSE_RST;
            ccw_count = 0;
            cw_count = 0;
            last_open = 1'b0;
            errors = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
            case (idx)
                REG_MIN_PULSE:      min_pulse = v[PULSE_W-1:0];
                REG_MAX_PULSE:      max_pulse = v[PULSE_W-1:0];
                REG_STEP_SIZE:      step_size = v[STEP_W-1:0];
                REG_OPEN_LEVEL:     open_level = v[PULSE_W-1:0];
                REG_CLOSE_LEVEL:    close_level = v[PULSE_W-1:0];
                REG_DIAL_THRESHOLD: dial_thr = v[THR_W-1:0];
                REG_HOLD_TICKS:     hold_ticks = v[THR_W-1:0];
                default: ;
            endcase
        endfunction

        function int next_hold(int count, bit beyond);
            if (!beyond)
                return 0;
            return (count < HOLD_MAX) ? count + 1 : HOLD_MAX;
        endfunction

        function void take_tick(logic [DIAL_W-1:0] dial_bits, tick_flags_t f);
            int d;
            int p;
            bit is_open;
            bit changed;
            pulse_beat_t b;
            d = $signed(dial_bits);
            ccw_count = next_hold(ccw_count, d > dial_thr);
            cw_count = next_hold(cw_count, d < -dial_thr);
            if (f.switch_up)
            begin
                ccw_count = 0;
                cw_count = 0;
            end
            p = pulse;
            if (f.match_phase == PHASE_NUDGE_DOWN)
                p = p - 1;
            else if (f.match_phase == PHASE_NUDGE_UP_A || f.match_phase == PHASE_NUDGE_UP_B)
                p = p + 1;
            if (f.ctrl_key_held || cw_count > hold_ticks)
                p = p - step_size;
            else if (f.plain_key_held || ccw_count > hold_ticks)
                p = p + step_size;
            // when the limits are crossed, a pulse below the lower limit takes it, any other the upper
            if (p < min_pulse)
                p = min_pulse;
            else if (p > max_pulse)
                p = max_pulse;
            pulse = p & 32'hFFF;
            is_open = last_open;
            changed = 1'b0;
            if (pulse <= open_level)
            begin
                is_open = 1'b1;
                changed = !last_open;
            end
            else if (pulse >= close_level)
            begin
                is_open = 1'b0;
                changed = last_open;
            end
            last_open = is_open;
            b.pulse_width = pulse[PULSE_W-1:0];
            b.cover_open = is_open;
            b.status_changed = changed;
            pending_beats.push_back(b);
        endfunction

        function void report(string field, logic [15:0] exp_v, logic [15:0] act_v);
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, field, exp_v, act_v);
        endfunction

        function void match_output(logic [PULSE_W-1:0] pw, logic is_open, logic changed);
            pulse_beat_t e;
            if (pending_beats.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat, pulse_width expected none actual %0d",
                         $time, pw);
                return;
            end
            e = pending_beats.pop_front();
            if (pw !== e.pulse_width)
                report("pulse_width", e.pulse_width, pw);
            if (is_open !== e.cover_open)
                report("cover_open", e.cover_open, is_open);
            if (changed !== e.status_changed)
                report("status_changed", e.status_changed, changed);
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata = '0;    // [10:0] dial
    logic [5:0]           s_tuser = '0;    // [0] ctrl, [1] plain, [2] switch_up, [5:3] phase
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [15:0]          m_tdata;         // [11:0] pulse_width
    logic [1:0]           m_tuser;         // [0] cover_open, [1] status_changed
    logic                 cfg_we = 1'b0;
    cfg_reg_t             cfg_index = REG_MIN_PULSE;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    servo_channel channel = new();
    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    bit hold_req = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;

    servo_pulse_ramp_with_cover_status dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD_OFF;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            channel.match_output(m_tdata[PULSE_W-1:0], m_tuser[0], m_tuser[1]);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_tick(input logic [DIAL_W-1:0] d, input bit c, input bit pl,
                             input bit sw, input logic [PHASE_W-1:0] ph);
        tick_flags_t f;
        f.ctrl_key_held = c;
        f.plain_key_held = pl;
        f.switch_up = sw;
        f.match_phase = ph;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(16-DIAL_W){1'b0}}, d};
        s_tuser <= f;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        channel.take_tick(d, f);
    endtask

    task automatic stop_and_drain();
        s_tvalid <= 1'b0;
        while (channel.pending_beats.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v[CFG_W-1:0];
        @(posedge clk);
        channel.set_reg(idx, v[CFG_W-1:0]);
    endtask

    task automatic apply_settings(input int lo, input int hi, input int stp, input int op,
                                  input int cl, input int thr, input int hld);
        write_reg(REG_MIN_PULSE, lo);
        write_reg(REG_MAX_PULSE, hi);
        write_reg(REG_STEP_SIZE, stp);
        write_reg(REG_OPEN_LEVEL, op);
        write_reg(REG_CLOSE_LEVEL, cl);
        write_reg(REG_DIAL_THRESHOLD, thr);
        write_reg(REG_HOLD_TICKS, hld);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [DIAL_W-1:0] dial_beyond(bit ccw);
        int lo;
        int v;
        lo = channel.dial_thr + 1;
        if (ccw)
        begin
            if (lo > 1023)
                v = 1023;
            else if (lo <= 660 && $urandom_range(3) != 0)
                v = $urandom_range(660, lo);
            else
                v = $urandom_range(1023, lo);
        end
        else
        begin
            if (lo > 1024)
                v = -1024;
            else if (lo <= 660 && $urandom_range(3) != 0)
                v = -$urandom_range(660, lo);
            else
                v = -$urandom_range(1024, lo);
        end
        return v[DIAL_W-1:0];
    endfunction

    function automatic logic [DIAL_W-1:0] dial_inside();
        int v;
        v = $urandom_range(2 * channel.dial_thr) - channel.dial_thr;
        return v[DIAL_W-1:0];
    endfunction

    // bursts of dial holds, key presses, nudges and noise
    task automatic run_bursts(input int n);
        int done;
        int len;
        int kind;
        bit dir;
        logic [DIAL_W-1:0] d;
        bit c, pl, sw;
        logic [PHASE_W-1:0] ph;
        done = 0;
        while (done < n)
        begin
            kind = $urandom_range(9);
            dir = 1'($urandom_range(1));
            len = $urandom_range(20, 1);
            if (kind < 6 && channel.hold_ticks < 100)
                len += channel.hold_ticks;
            for (int i = 0; i < len; i++)
            begin
                c = ($urandom_range(15) == 0);
                pl = ($urandom_range(15) == 0);
                sw = ($urandom_range(31) == 0);
                ph = PHASE_W'($urandom_range(7));
                case (kind)
                    0, 1, 2: d = dial_beyond(1'b1);
                    3, 4, 5: d = dial_beyond(1'b0);
                    6:
                    begin
                        c = 1'($urandom_range(1));
                        pl = 1'($urandom_range(1));
                        d = dial_inside();
                    end
                    7:
                    begin
                        d = DIAL_W'($urandom);
                        c = 1'($urandom_range(1));
                        pl = 1'($urandom_range(1));
                        sw = 1'($urandom_range(1));
                    end
                    8:
                    begin
                        // hold broken by the switch or a dial drop
                        d = (i == len / 3) ? dial_inside() : dial_beyond(dir);
                        sw = (i == (2 * len) / 3);
                    end
                    default: d = dial_inside();
                endcase
                send_tick(d, c, pl, sw, ph);
                done++;
            end
        end
    endtask

    task automatic segment_settings(input int seg);
        int lo, hi, stp, op, cl, thr, hld;
        lo = $urandom_range(1200);
        hi = lo + $urandom_range(1300);
        stp = $urandom_range(40, 1);
        if ($urandom_range(4) == 0)
            stp = 255;
        op = lo + $urandom_range(hi - lo);
        cl = op + $urandom_range(hi - op);
        thr = $urandom_range(660);
        hld = $urandom_range(40);
        case (seg)
            1:
            begin
                thr = 0;
                hld = 0;
            end
            2: stp = 0;
            3:
            begin
                lo = 2500;
                hi = 800;
            end
            5:
            begin
                op = 2000;
                cl = 1000;
            end
            7:
            begin
                thr = 1023;
                hld = 1023;
            end
            9:
            begin
                lo = 0;
                hi = 4095;
                stp = 255;
                op = 0;
                cl = 4095;
                thr = 660;
            end
            10:
            begin
                lo = 4095;
                hi = 0;
                op = 4095;
                cl = 0;
            end
            11:
            begin
                lo = MIN_PULSE_RST;
                hi = MAX_PULSE_RST;
                stp = STEP_SIZE_RST;
                op = OPEN_LEVEL_RST;
                cl = CLOSE_LEVEL_RST;
                thr = DIAL_THR_RST;
                hld = HOLD_TICKS_RST;
            end
            default: ;
        endcase
        apply_settings(lo, hi, stp, op, cl, thr, hld);
    endtask

    initial
    begin
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        src_idle_pct = 33;
        sink_idle_pct = 56;

        send_tick('0, 1'b0, 1'b0, 1'b0, PHASE_IDLE);
        for (int ph = 1; ph < 8; ph++)
            send_tick('0, 1'b0, 1'b0, 1'b0, ph[PHASE_W-1:0]);
        send_tick('0, 1'b1, 1'b0, 1'b0, PHASE_IDLE);
        send_tick('0, 1'b0, 1'b1, 1'b0, PHASE_IDLE);
        send_tick('0, 1'b1, 1'b1, 1'b0, PHASE_NUDGE_UP_A);
        send_tick(11'sd1023, 1'b0, 1'b0, 1'b0, PHASE_IDLE);
        send_tick(-11'sd1024, 1'b0, 1'b0, 1'b0, PHASE_IDLE);
        send_tick(11'sd660, 1'b0, 1'b0, 1'b0, PHASE_IDLE);
        send_tick(-11'sd660, 1'b0, 1'b0, 1'b0, PHASE_IDLE);
        send_tick(11'sd660, 1'b0, 1'b0, 1'b1, PHASE_IDLE);
        stop_and_drain();

        // drive the pulse below zero, then up against the upper limit
        apply_settings(0, 2500, 255, OPEN_LEVEL_RST, CLOSE_LEVEL_RST, DIAL_THR_RST,
                       HOLD_TICKS_RST);
        repeat (7)
            send_tick('0, 1'b1, 1'b0, 1'b0, PHASE_IDLE);
        repeat (10)
            send_tick('0, 1'b0, 1'b1, 1'b0, PHASE_IDLE);

        for (int seg = 0; seg < 12; seg++)
        begin
            stop_and_drain();
            if (seg < 4)
            begin
                src_idle_pct = 33;
                sink_idle_pct = 56;
            end
            else if (seg < 8)
            begin
                src_idle_pct = 56;
                sink_idle_pct = 33;
            end
            else
            begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end
            segment_settings(seg);
            if (seg == 1)
                hold_req <= ~hold_req;
            run_bursts(125);
        end

        stop_and_drain();
        repeat (8)
            @(posedge clk);
        if (channel.errors == 0 && channel.pending_beats.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
